[hdl/unsigned_divider_64_macros.svh]
`ifndef UNSIGNED_DIVIDER_64_MACROS_SVH
`define UNSIGNED_DIVIDER_64_MACROS_SVH

// clocked check, masked while reset is high
`define UD64_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, live through reset
`define UD64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/udiv64_pkg.sv]
package udiv64_pkg;

   localparam int FIELD_W        = 64;
   localparam int DATA_BYTES_DEF = 8;
   localparam int STATUS_W       = 2;

   localparam logic [STATUS_W-1:0] STAT_LESS    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EQUAL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_GREATER = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DIVZERO = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] dividend;
      logic [FIELD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0]  quotient;
      logic [FIELD_W-1:0]  remainder;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_RUN,
      S_FIN
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

endpackage

[hdl/udiv64_core.sv]
module udiv64_core #(
   parameter int OP_W = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [OP_W-1:0]            dividend,
   input  logic [OP_W-1:0]            divisor,
   output logic [OP_W-1:0]            quotient,
   output logic [OP_W-1:0]            remainder,
   output udiv64_pkg::core_stat_type  stat
);

   localparam int CNT_W = $clog2(OP_W + 1);

   logic [OP_W-1:0]  rem_ff, rem_in;
   logic [OP_W-1:0]  quo_ff, quo_in;
   logic [OP_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [OP_W:0]    shifted;
   logic [OP_W:0]    diff;

   // one restoring step: shift in the next dividend bit, trial subtract
   assign shifted = {rem_ff, quo_ff[OP_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(OP_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[OP_W]) begin
            rem_in = diff[OP_W-1:0];
         end else begin
            rem_in = shifted[OP_W-1:0];
         end
         quo_in = {quo_ff[OP_W-2:0], ~diff[OP_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/unsigned_divider_64.sv]
// Unsigned restoring divider. Operands are DATA_BYTES*8 bits wide (64 at most); input bits
// above that width are ignored and results are zero-extended to 64 bits. A request is
// taken only while req_ready is high, i.e. while no division is in progress. State S_CMP
// compares the operands; less, equal and nonzero-over-zero go from there to S_FIN, where
// the result is loaded into the output register. Otherwise a single shared subtractor in
// the core yields one quotient bit per cycle in S_RUN, then S_FIN loads the result. The
// next request can be taken from the cycle after the load, so no new request is taken
// before the last one is through; a result still waiting in the output register holds
// the following one back until it is transferred. Status: 0 dividend less, 1 equal,
// 2 dividend greater, 3 divide by zero (quotient 0, remainder = dividend).
module unsigned_divider_64 #(
   parameter int DATA_BYTES = udiv64_pkg::DATA_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  udiv64_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output udiv64_pkg::rsp_type rsp_data
);

   localparam int OP_W = (DATA_BYTES * 8 > udiv64_pkg::FIELD_W) ?
                         udiv64_pkg::FIELD_W : DATA_BYTES * 8;

   udiv64_pkg::state_type     state_ff, state_in;
   logic [OP_W-1:0]           n_ff, n_in;
   logic [OP_W-1:0]           d_ff, d_in;
   logic [udiv64_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   udiv64_pkg::rsp_type       rsp_ff, rsp_in;

   logic                      take_req;
   logic                      core_start;
   logic                      rsp_load;
   logic [udiv64_pkg::STATUS_W-1:0] cmp_status;
   logic [OP_W-1:0]           core_quo;
   logic [OP_W-1:0]           core_rem;
   udiv64_pkg::core_stat_type core_stat;

   udiv64_core #(
      .OP_W (OP_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .quotient  (core_quo),
      .remainder (core_rem),
      .stat      (core_stat)
   );

   always_comb begin
      if (n_ff < d_ff) begin
         cmp_status = udiv64_pkg::STAT_LESS;
      end else if (n_ff == d_ff) begin
         cmp_status = udiv64_pkg::STAT_EQUAL;
      end else if (d_ff == '0) begin
         cmp_status = udiv64_pkg::STAT_DIVZERO;
      end else begin
         cmp_status = udiv64_pkg::STAT_GREATER;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         udiv64_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = udiv64_pkg::S_CMP;
            end
         end
         udiv64_pkg::S_CMP: begin
            if (cmp_status == udiv64_pkg::STAT_GREATER) begin
               state_in = udiv64_pkg::S_RUN;
            end else begin
               state_in = udiv64_pkg::S_FIN;
            end
         end
         udiv64_pkg::S_RUN: begin
            if (core_stat.done) begin
               state_in = udiv64_pkg::S_FIN;
            end
         end
         udiv64_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = udiv64_pkg::S_IDLE;
            end
         end
         default: state_in = udiv64_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == udiv64_pkg::S_IDLE);
      core_start = (state_ff == udiv64_pkg::S_CMP) &&
                   (cmp_status == udiv64_pkg::STAT_GREATER);
      rsp_load   = (state_ff == udiv64_pkg::S_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   assign take_req = req_valid && req_ready;

   always_comb begin
      n_in      = take_req ? req_data.dividend[OP_W-1:0] : n_ff;
      d_in      = take_req ? req_data.divisor[OP_W-1:0] : d_ff;
      status_in = (state_ff == udiv64_pkg::S_CMP) ? cmp_status : status_ff;

      rsp_in.status = status_ff;
      case (status_ff)
         udiv64_pkg::STAT_GREATER: begin
            rsp_in.quotient  = udiv64_pkg::FIELD_W'(core_quo);
            rsp_in.remainder = udiv64_pkg::FIELD_W'(core_rem);
         end
         udiv64_pkg::STAT_EQUAL: begin
            rsp_in.quotient  = udiv64_pkg::FIELD_W'(1);
            rsp_in.remainder = '0;
         end
         default: begin
            rsp_in.quotient  = '0;
            rsp_in.remainder = udiv64_pkg::FIELD_W'(n_ff);
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      d_ff      <= d_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= udiv64_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/udiv64_checker.sv]
`include "unsigned_divider_64_macros.svh"

module udiv64_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input udiv64_pkg::rsp_type rsp_data
);

   `UD64_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data),
      "result changed or dropped while stalled")
   `UD64_ASSERT(a_busy_after_req, clock, reset,
      req_valid && req_ready |=> !req_ready,
      "new request taken while a division is in progress")
   `UD64_ASSERT(a_equal_result, clock, reset,
      rsp_valid && rsp_data.status == udiv64_pkg::STAT_EQUAL |->
         rsp_data.quotient == 64'd1 && rsp_data.remainder == 64'd0,
      "equal operands gave wrong result")
   `UD64_ASSERT(a_zero_quotient, clock, reset,
      rsp_valid && (rsp_data.status == udiv64_pkg::STAT_LESS ||
         rsp_data.status == udiv64_pkg::STAT_DIVZERO) |-> rsp_data.quotient == 64'd0,
      "nonzero quotient for less or divide by zero")
   `UD64_ASSERT_ALWAYS(a_reset_idle, clock,
      $past(reset) |-> !rsp_valid,
      "result transfer offered straight after reset")

endmodule

bind unsigned_divider_64 udiv64_checker u_checker (.*);

[test/unsigned_divider_64_tb.sv]
`timescale 1ns / 1ps

module unsigned_divider_64_tb;

   localparam int OP_W = (udiv64_pkg::DATA_BYTES_DEF * 8 > 64 ||
                          udiv64_pkg::DATA_BYTES_DEF == 0) ? 64
                         : udiv64_pkg::DATA_BYTES_DEF * 8;
   localparam logic [udiv64_pkg::FIELD_W-1:0] OP_MASK = (OP_W >= 64) ? '1
                                            : ((64'd1 << OP_W) - 64'd1);
   localparam logic [udiv64_pkg::FIELD_W-1:0] ALL_ONES = '1;
   localparam logic [udiv64_pkg::FIELD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_FROM    = 700;
   localparam int QUIET_TO      = 900;
   localparam int IDLE_PERCENT  = 6;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   udiv64_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   udiv64_pkg::rsp_type rsp_data;

   udiv64_pkg::req_type operands_q[$];
   udiv64_pkg::rsp_type quot_rem_q[$];

   int cycle_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int error_count   = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int status_seen[4] = '{0, 0, 0, 0};

   wire quiet = (checked_count >= QUIET_FROM) && (checked_count < QUIET_TO);

   unsigned_divider_64 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic udiv64_pkg::rsp_type udiv_result(udiv64_pkg::req_type item);
      logic [udiv64_pkg::FIELD_W-1:0] n;
      logic [udiv64_pkg::FIELD_W-1:0] d;
      udiv64_pkg::rsp_type res;
      n = item.dividend & OP_MASK;
      d = item.divisor & OP_MASK;
      res = '0;
      if (n < d) begin
         res.status    = udiv64_pkg::STAT_LESS;
         res.remainder = n;
      end else if (n == d) begin
         res.status   = udiv64_pkg::STAT_EQUAL;
         res.quotient = 64'd1;
      end else if (d == 0) begin
         res.status    = udiv64_pkg::STAT_DIVZERO;
         res.remainder = n;
      end else begin
         res.status    = udiv64_pkg::STAT_GREATER;
         res.quotient  = (n / d) & OP_MASK;
         res.remainder = (n % d) & OP_MASK;
      end
      return res;
   endfunction

   // random value of exactly len significant bits
   function automatic logic [udiv64_pkg::FIELD_W-1:0] rand_len(int len);
      logic [udiv64_pkg::FIELD_W-1:0] v;
      v = {$urandom, $urandom};
      if (len <= 0)
         return '0;
      if (len < 64)
         v &= (64'd1 << len) - 64'd1;
      v[len-1] = 1'b1;
      return v;
   endfunction

   task automatic add_division(logic [udiv64_pkg::FIELD_W-1:0] n,
                               logic [udiv64_pkg::FIELD_W-1:0] d);
      udiv64_pkg::req_type item;
      item.dividend = n;
      item.divisor  = d;
      operands_q.push_back(item);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            quot_rem_q.push_back(udiv_result(req_data));
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (operands_q.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_data  <= operands_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      udiv64_pkg::rsp_type want;
      int                  bad;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bad = 0;
            if (quot_rem_q.size() == 0) begin
               $error("result with no division outstanding: q=%h r=%h status=%0d",
                      rsp_data.quotient, rsp_data.remainder, rsp_data.status);
               bad = 1;
            end else begin
               want = quot_rem_q.pop_front();
               if (rsp_data.quotient !== want.quotient) begin
                  $error("quotient: expected %h, got %h", want.quotient, rsp_data.quotient);
                  bad++;
               end
               if (rsp_data.remainder !== want.remainder) begin
                  $error("remainder: expected %h, got %h",
                         want.remainder, rsp_data.remainder);
                  bad++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  bad++;
               end
               status_seen[want.status] <= status_seen[want.status] + 1;
            end
            checked_count <= checked_count + 1;
            error_count   <= error_count + bad;
         end
         // hold off once, long enough for the divider to fill and stall its input
         if (!hold_done && checked_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, quot_rem_q.size());
         $display("** unsigned_divider_64: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [udiv64_pkg::FIELD_W-1:0] n;
      logic [udiv64_pkg::FIELD_W-1:0] d;
      logic [udiv64_pkg::FIELD_W-1:0] k;
      int dlen;
      int pick;

      add_division(64'd0, 64'd0);
      add_division(64'd0, 64'd1);
      add_division(64'd0, ALL_ONES);
      add_division(ALL_ONES, ALL_ONES);
      add_division(ALL_ONES, 64'd1);
      add_division(ALL_ONES, 64'd0);
      add_division(64'd1, 64'd0);
      add_division(TOP_BIT, 64'd0);
      add_division(ALL_ONES, 64'd2);
      add_division(64'd1, ALL_ONES);
      add_division(64'd1, 64'd1);
      add_division(TOP_BIT, 64'd1);
      add_division(TOP_BIT, TOP_BIT);
      add_division(TOP_BIT - 64'd1, TOP_BIT);
      add_division(ALL_ONES, TOP_BIT);
      add_division(ALL_ONES, TOP_BIT + 64'd1);
      add_division(64'd100, 64'd7);
      add_division(64'd7, 64'd100);
      add_division(TOP_BIT, 64'd3);
      add_division(ALL_ONES, 64'hffff_ffff);
      add_division(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      add_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      add_division(64'h1234_5678_9abc_def0, 64'h0fed_cba9);
      add_division(ALL_ONES - 64'd1, ALL_ONES);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            n = rand_len($urandom_range(1, 64));
            d = rand_len($urandom_range(1, 64));
         end else if (pick < 50) begin
            n = {$urandom, $urandom};
            d = {$urandom, $urandom};
         end else if (pick < 60) begin
            n = {$urandom, $urandom};
            d = rand_len($urandom_range(1, 8));
         end else if (pick < 68) begin
            n = {$urandom, $urandom};
            d = n;
         end else if (pick < 76) begin
            n = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_len($urandom_range(1, 64));
            d = 64'd0;
         end else if (pick < 86) begin
            d = rand_len($urandom_range(1, 64));
            n = {$urandom, $urandom} % d;
         end else begin
            dlen = $urandom_range(1, 63);
            d = rand_len(dlen);
            k = rand_len($urandom_range(1, 64 - dlen));
            n = d * k + (($urandom_range(0, 1) == 1) ? d - 64'd1 : 64'd0);
         end
         add_division(n, d);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (operands_q.size() != 0 || req_valid || quot_rem_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (quot_rem_q.size() != 0) begin
         $error("%0d results never arrived", quot_rem_q.size());
         error_count++;
      end

      $display("%0d divisions sent, %0d results checked: %0d less, %0d equal, %0d greater,",
               sent_count, checked_count, status_seen[udiv64_pkg::STAT_LESS],
               status_seen[udiv64_pkg::STAT_EQUAL], status_seen[udiv64_pkg::STAT_GREATER]);
      $display("%0d by zero; one %0d-cycle receiver hold-off, random stalls on both sides",
               status_seen[udiv64_pkg::STAT_DIVZERO], HOLD_CYCLES);
      if (error_count == 0)
         $display("** unsigned_divider_64: PASSED **");
      else
         $display("** unsigned_divider_64: FAILED **");
      $finish;
   end

endmodule

[unsigned_divider_64.f]
+incdir+hdl
hdl/udiv64_pkg.sv
hdl/udiv64_core.sv
hdl/unsigned_divider_64.sv
hdl/udiv64_checker.sv
test/unsigned_divider_64_tb.sv
